// File: design/rrha_pkg.sv
package rrha_pkg;

  // Field widths of the request and response items
  localparam int REQ_W    = 2;
  localparam int HANDLE_W = 8;
  localparam int SOCK_W   = 16;
  localparam int STATUS_W = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  // Widest bitmap word read per cycle
  localparam int MAP_WORD_MAX = 32;

endpackage

// File: design/rrha_if.sv
interface rrha_req_if
  import rrha_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [HANDLE_W-1:0] handle_in;
  logic [SOCK_W-1:0]   socket_id;

  modport source (output valid, req_type, handle_in, socket_id, input ready);
  modport sink   (input valid, req_type, handle_in, socket_id, output ready);
endinterface

interface rrha_rsp_if
  import rrha_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] handle_out;
  logic [SOCK_W-1:0]   socket_out;
  logic [STATUS_W-1:0] status;
  logic                all_free;

  modport source (output valid, handle_out, socket_out, status, all_free, input ready);
  modport sink   (input valid, handle_out, socket_out, status, all_free, output ready);
endinterface

// File: design/round_robin_handle_allocator.sv
// Round-robin handle allocator. Handles 1..HANDLES-1 are granted round-robin,
// starting just after the last handle granted; handle 0 is never granted. The
// used bitmap sits in a memory of W-bit words (W up to 32; ROWS = ceil(HANDLES/W)
// words, 8 at the default size) and the socket ids in a second memory, both
// with a registered read. An allocate reads one bitmap word per cycle through
// the single read port until it finds a free handle or has checked every word;
// a full table is answered without a search. Release and lookup read the
// handle's word and then check it; an invalid handle or an unknown request skips
// the check. One item is worked on at a time; a finished result waits in an
// output register while the next item is accepted. After reset a clearing pass
// over all ROWS words zeroes the bitmap before the first item is accepted.
module round_robin_handle_allocator
  import rrha_pkg::*;
#(
  parameter int HANDLES = 256
) (
  input  logic         clk,
  input  logic         rst,
  rrha_req_if.sink     req,
  rrha_rsp_if.source   rsp
);

  // Bitmap geometry
  localparam int W         = (HANDLES >= MAP_WORD_MAX) ? MAP_WORD_MAX :
                             (HANDLES >= 16) ? 16 : (HANDLES >= 8) ? 8 : 4;
  localparam int BW        = $clog2(W);
  localparam int ROWS      = (HANDLES + W - 1) / W;
  localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SW        = RW + BW;
  localparam int STW       = $clog2(ROWS + 2);
  localparam int LW        = $clog2(HANDLES);
  localparam int LAST_BITS = HANDLES - (ROWS - 1) * W;

  typedef enum logic [2:0] {CLEAR, IDLE, SEARCH, CHECK, DONE} state_t;

  state_t state;

  // Memories
  logic [W-1:0]      used_mem [ROWS];
  logic [SOCK_W-1:0] sock_mem [HANDLES];
  logic [W-1:0]      used_rd;
  logic [SOCK_W-1:0] sock_rd;

  // Control and item registers
  logic [SW-1:0]       last_granted;
  logic [LW-1:0]       live_count;
  logic [RW-1:0]       clr_row;
  logic [REQ_W-1:0]    cur_req;
  logic [SOCK_W-1:0]   cur_sock;
  logic [SW-1:0]       cur_slot;
  logic [BW-1:0]       start_bit;
  logic [RW-1:0]       iss_row;
  logic [STW-1:0]      iss_step;
  logic                chk_valid;
  logic [RW-1:0]       chk_row;
  logic [STW-1:0]      chk_step;
  logic [HANDLE_W-1:0] res_handle;
  logic [SOCK_W-1:0]   res_sock;
  logic [STATUS_W-1:0] res_status;
  logic                out_valid;
  logic [HANDLE_W-1:0] out_handle;
  logic [SOCK_W-1:0]   out_sock;
  logic [STATUS_W-1:0] out_status;
  logic                out_free;

  // Combinational signals
  logic          accept;
  logic          handle_ok;
  logic [SW-1:0] hslot;
  logic [SW:0]   next_start;
  logic [SW-1:0] start_slot;
  logic [RW-1:0] rd_row;
  logic [SW-1:0] rd_slot;
  logic [W-1:0]  search_mask;
  logic [W-1:0]  free_bits;
  logic          free_found;
  logic [BW-1:0] free_idx;
  logic [SW-1:0] found_slot;
  logic          hit;
  logic          um_we;
  logic [RW-1:0] um_wa;
  logic [W-1:0]  um_wd;
  logic          table_full;
  logic          out_open;

  assign accept     = req.valid && req.ready;
  assign req.ready  = (state == IDLE);
  assign handle_ok  = (req.handle_in != '0) && (32'(req.handle_in) < HANDLES);
  assign hslot      = SW'(req.handle_in);
  assign table_full = (live_count == LW'(HANDLES - 1));
  assign out_open   = !out_valid || rsp.ready;

  // Start the search just after the last handle granted, wrapping at the top
  assign next_start = {1'b0, last_granted} + (SW + 1)'(1);
  assign start_slot = (next_start == (SW + 1)'(HANDLES)) ? '0 : next_start[SW-1:0];

  // Read address: the handle's word when idle, the search word otherwise
  always_comb begin
    if (state == IDLE) begin
      rd_row  = handle_ok ? hslot[SW-1:BW] : '0;
      rd_slot = handle_ok ? hslot : '0;
    end else begin
      rd_row  = iss_row;
      rd_slot = '0;
    end
  end

  // Mask the checked word: start offset, wrap tail, slot 0, slots past the top
  always_comb begin
    for (int i = 0; i < W; i++) begin
      search_mask[i] = 1'b1;
      if (chk_step == '0 && BW'(i) < start_bit) search_mask[i] = 1'b0;
      if (chk_step == STW'(ROWS) && BW'(i) >= start_bit) search_mask[i] = 1'b0;
      if (chk_row == '0 && i == 0) search_mask[i] = 1'b0;
      if (chk_row == RW'(ROWS - 1) && i >= LAST_BITS) search_mask[i] = 1'b0;
    end
  end

  // Pick the lowest free slot in the checked word
  assign free_bits  = ~used_rd & search_mask;
  assign free_found = chk_valid && (free_bits != '0);
  always_comb begin
    free_idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (free_bits[i]) free_idx = BW'(i);
    end
  end
  assign found_slot = {chk_row, free_idx};

  // Used bit of the handle under release or lookup
  assign hit = used_rd[cur_slot[BW-1:0]];

  // Bitmap write port
  always_comb begin
    um_we = 1'b0;
    um_wa = '0;
    um_wd = '0;
    unique case (state)
      CLEAR: begin
        um_we = 1'b1;
        um_wa = clr_row;
      end
      SEARCH: begin
        um_we = free_found;
        um_wa = chk_row;
        um_wd = used_rd | (W'(1) << free_idx);
      end
      CHECK: begin
        um_we = (cur_req == REQ_RELEASE) && hit;
        um_wa = cur_slot[SW-1:BW];
        um_wd = used_rd & ~(W'(1) << cur_slot[BW-1:0]);
      end
      default: begin
        um_we = 1'b0;
      end
    endcase
  end

  // Memories: one write and one read per cycle each
  always_ff @(posedge clk) begin
    if (um_we) used_mem[um_wa] <= um_wd;
    used_rd <= used_mem[rd_row];
    if (state == SEARCH && free_found) sock_mem[found_slot] <= cur_sock;
    sock_rd <= sock_mem[rd_slot];
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CLEAR;
      clr_row      <= '0;
      last_granted <= '0;
      live_count   <= '0;
      chk_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // Load the output register from a finished item, else drop it on handshake
      if (state == DONE && out_open) out_valid <= 1'b1;
      else if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        CLEAR: begin
          clr_row <= clr_row + RW'(1);
          if (clr_row == RW'(ROWS - 1)) state <= IDLE;
        end
        IDLE: begin
          if (accept) begin
            cur_req    <= req.req_type;
            cur_sock   <= req.socket_id;
            cur_slot   <= hslot;
            res_handle <= '0;
            res_sock   <= '0;
            start_bit  <= start_slot[BW-1:0];
            iss_row    <= start_slot[SW-1:BW];
            iss_step   <= '0;
            chk_valid  <= 1'b0;
            case (req.req_type)
              REQ_ALLOC: begin
                if (table_full) begin
                  res_status <= ST_FULL;
                  state      <= DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= SEARCH;
                end
              end
              REQ_RELEASE: begin
                res_status <= ST_OK;
                state      <= handle_ok ? CHECK : DONE;
              end
              REQ_LOOKUP: begin
                if (handle_ok) begin
                  res_status <= ST_OK;
                  state      <= CHECK;
                end else begin
                  res_status <= ST_BAD;
                  state      <= DONE;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= DONE;
              end
            endcase
          end
        end
        SEARCH: begin
          // Issue the next word read while checking the word that returned
          chk_row   <= iss_row;
          chk_step  <= iss_step;
          if (iss_step <= STW'(ROWS)) begin
            iss_step <= iss_step + STW'(1);
            iss_row  <= (iss_row == RW'(ROWS - 1)) ? '0 : iss_row + RW'(1);
          end
          if (free_found) begin
            last_granted <= found_slot;
            live_count   <= live_count + LW'(1);
            res_handle   <= HANDLE_W'(found_slot);
            chk_valid    <= 1'b0;
            state        <= DONE;
          end else if (chk_valid && chk_step == STW'(ROWS)) begin
            res_status <= ST_FULL;
            chk_valid  <= 1'b0;
            state      <= DONE;
          end else begin
            chk_valid <= (iss_step <= STW'(ROWS));
          end
        end
        CHECK: begin
          if (cur_req == REQ_RELEASE) begin
            if (hit && live_count != '0) live_count <= live_count - LW'(1);
          end else if (hit) begin
            res_sock <= sock_rd;
          end else begin
            res_status <= ST_BAD;
          end
          state <= DONE;
        end
        DONE: begin
          if (out_open) begin
            out_handle <= res_handle;
            out_sock   <= res_sock;
            out_status <= res_status;
            out_free   <= (live_count == '0);
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.handle_out = out_handle;
  assign rsp.socket_out = out_sock;
  assign rsp.status     = out_status;
  assign rsp.all_free   = out_free;

  // A granted slot is never the reserved handle and lies inside the table
  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    (state == SEARCH && free_found) |-> (found_slot != '0 && 32'(found_slot) < HANDLES))
    else $error("granted slot out of range");

  // An accepted item always leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != IDLE))
    else $error("accepted item not taken up");

  // A full table can never be empty
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> !rsp.all_free)
    else $error("full status with all handles free");

  // The bitmap is written only while clearing or working on an item
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE || state == DONE) |-> !um_we)
    else $error("bitmap write while idle");

  // The live count moves only in the search or check step
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (live_count != $past(live_count)) |->
      ($past(state) == SEARCH || $past(state) == CHECK || $past(rst)))
    else $error("live count changed outside an item");

endmodule
